// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock edge, off while reset is held
`define CHECK_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that stays armed through reset
`define CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/psc_pkg.sv =====
package psc_pkg;

    localparam int ID_W       = 8;
    localparam int BURST_W    = 16;
    localparam int PRIO_W     = 8;
    localparam int TIME_W     = 21;
    localparam int TOT_W      = 26;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 104;

    // one stored job
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    id;
    } t_job;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic drain;
    } t_cell_ctrl;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

endpackage

// ===== sv/psc_cell.sv =====
`include "assert_macros.svh"

module psc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psc_pkg::t_cell_ctrl i_ctrl,
    input  psc_pkg::t_job     i_new,
    input  logic              i_prev_valid,
    input  psc_pkg::t_job     i_prev,
    input  logic              i_prev_greater,
    input  logic              i_next_valid,
    input  psc_pkg::t_job     i_next,
    output logic              o_valid,
    output psc_pkg::t_job     o_job,
    output logic              o_greater
);
    import psc_pkg::*;

    logic r_valid;
    t_job r_job;
    logic n_valid;
    t_job n_job;
    logic w_greater;

    // an empty cell ranks behind everything; ties keep load order
    assign w_greater = !r_valid || (r_job.prio > i_new.prio);

    // insert: make room by shifting the tail one cell down; drain: shift towards the head
    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        priority if (i_ctrl.insert) begin
            if (w_greater) begin
                if (i_prev_greater) begin
                    n_valid = i_prev_valid;
                    n_job   = i_prev;
                end else begin
                    n_valid = 1'b1;
                    n_job   = i_new;
                end
            end
        end else if (i_ctrl.drain) begin
            n_valid = i_next_valid;
            n_job   = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    assign o_valid   = r_valid;
    assign o_job     = r_job;
    assign o_greater = w_greater;

    // occupied cells stay packed at the head and in ascending priority
    `CHECK_PROP(a_packed, i_clk, i_rst_n, !r_valid |-> !i_next_valid, "gap in cell chain")
    `CHECK_PROP(a_sorted, i_clk, i_rst_n, (r_valid && i_next_valid) |-> (r_job.prio <= i_next.prio), "cell chain out of order")

endmodule

// ===== sv/priority_schedule_times.sv =====
// Non-preemptive priority scheduler. Jobs (id, burst, priority) stream in at one
// beat per cycle and are sorted on arrival by a chain of MAX_PROCS insertion cells;
// lower priority values come first and equal priorities keep their arrival order.
// The beat with tlast closes the set: input is then held off while the chain drains
// from its head, one result beat per cycle unless the output stalls, each beat giving
// the job's completion and waiting time and the running totals. Jobs arriving with
// the chain full are discarded and every result of that set carries the dropped
// flag in tuser. Loading resumes as soon as the last result sits in the output
// register.
`include "assert_macros.svh"

module priority_schedule_times #(
    parameter int MAX_PROCS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // s tdata: job_id[7:0], burst[23:8], prio[31:24]; tlast: last_job
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,
    input  logic         i_s_tlast,
    // m tdata: out_id[7:0], completion[28:8], wait_time[49:29],
    //          total_wait[75:50], total_turnaround[101:76], zero pad[103:102]
    // tuser: dropped; tlast: last_out
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,
    output logic         o_m_tuser,
    output logic         o_m_tlast
);
    import psc_pkg::*;

    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int NOW_W = BURST_W + $clog2(MAX_PROCS);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_left, n_left;
    logic               r_ovf, n_ovf;
    logic [NOW_W-1:0]   r_now, n_now;
    logic [TOT_W-1:0]   r_twait, n_twait;
    logic [TOT_W-1:0]   r_tturn, n_tturn;
    logic               r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data, n_m_data;
    logic               r_m_user, n_m_user;
    logic               r_m_last, n_m_last;

    t_cell_ctrl         w_ctrl;
    t_job               w_new;
    logic               w_accept;
    logic               w_emit;
    logic [NOW_W-1:0]   w_now_sum;

    logic               w_valid   [MAX_PROCS];
    t_job               w_job     [MAX_PROCS];
    logic               w_greater [MAX_PROCS];

    assign w_new = t_job'(i_s_tdata[IN_DATA_W-1:0]);

    // sorting chain
    for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
        logic w_pv;
        t_job w_pj;
        logic w_pg;
        logic w_nv;
        t_job w_nj;
        if (g == 0) begin : g_head
            assign w_pv = 1'b0;
            assign w_pj = w_new;
            assign w_pg = 1'b0;
        end else begin : g_mid
            assign w_pv = w_valid[g-1];
            assign w_pj = w_job[g-1];
            assign w_pg = w_greater[g-1];
        end
        if (g == MAX_PROCS - 1) begin : g_tail
            assign w_nv = 1'b0;
            assign w_nj = w_new;
        end else begin : g_body
            assign w_nv = w_valid[g+1];
            assign w_nj = w_job[g+1];
        end
        psc_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (w_ctrl),
            .i_new          (w_new),
            .i_prev_valid   (w_pv),
            .i_prev         (w_pj),
            .i_prev_greater (w_pg),
            .i_next_valid   (w_nv),
            .i_next         (w_nj),
            .o_valid        (w_valid[g]),
            .o_job          (w_job[g]),
            .o_greater      (w_greater[g])
        );
    end

    assign o_s_tready = (r_state == ST_LOAD);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_emit     = (r_state == ST_DRAIN) && (!r_m_valid || i_m_tready);
    assign w_now_sum  = r_now + NOW_W'(w_job[0].burst);

    // load and drain control
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_ovf     = r_ovf;
        n_now     = r_now;
        n_twait   = r_twait;
        n_tturn   = r_tturn;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        n_m_last  = r_m_last;
        w_ctrl    = '0;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (r_count < CNT_W'(MAX_PROCS)) begin
                        w_ctrl.insert = 1'b1;
                        n_count       = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_state = ST_DRAIN;
                        n_left  = n_count;
                        n_now   = '0;
                        n_twait = '0;
                        n_tturn = '0;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_emit) begin
                    w_ctrl.drain = 1'b1;
                    n_now     = w_now_sum;
                    n_twait   = r_twait + TOT_W'(r_now);
                    n_tturn   = r_tturn + TOT_W'(w_now_sum);
                    n_m_valid = 1'b1;
                    n_m_data  = {2'b00, n_tturn, n_twait, TIME_W'(r_now),
                                 TIME_W'(w_now_sum), w_job[0].id};
                    n_m_user  = r_ovf;
                    n_m_last  = (r_left == CNT_W'(1));
                    n_left    = r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = ST_LOAD;
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_left    <= '0;
            r_ovf     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_ovf     <= n_ovf;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now    <= n_now;
        r_twait  <= n_twait;
        r_tturn  <= n_tturn;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

    // drain bookkeeping matches what the chain holds
    `CHECK_PROP(a_drain_left, i_clk, i_rst_n, (r_state == ST_DRAIN) |-> (r_left != '0), "drain with nothing left")
    `CHECK_PROP(a_drain_head, i_clk, i_rst_n, (r_state == ST_DRAIN) |-> w_valid[0], "drain from empty chain head")
    `CHECK_PROP(a_last_done, i_clk, i_rst_n, (w_emit && r_left == CNT_W'(1)) |=> (r_state == ST_LOAD && !w_valid[0]), "chain not empty after final beat")

endmodule

// ===== bench/priority_schedule_times_tb.sv =====
module priority_schedule_times_tb;
    import psc_pkg::*;

    localparam int JOB_SLOTS     = 32;
    localparam int RANDOM_JOBS   = 120;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;
    localparam int PAD_W         = OUT_DATA_W - ID_W - 2 * TIME_W - 2 * TOT_W;

    // result beat layout on the master tdata, highest field first
    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [TOT_W-1:0]  tot_turnaround;
        logic [TOT_W-1:0]  tot_wait;
        logic [TIME_W-1:0] wait_time;
        logic [TIME_W-1:0] completion;
        logic [ID_W-1:0]   out_id;
    } t_sched_data;

    typedef struct {
        t_sched_data data;
        logic        dropped;
        logic        last;
    } t_sched_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  i_s_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    // predictor state: jobs of the open set and the schedule still owed
    t_job        pending_jobs[$];
    logic        pending_dropped = 1'b0;
    t_sched_beat sched_q[$];

    int unsigned jobs_sent      = 0;
    int unsigned sets_sent      = 0;
    int unsigned dropped_sets   = 0;
    int unsigned beats_checked  = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // source and sink pacing controls
    bit          src_gaps    = 1'b0;
    bit          sink_stalls = 1'b0;
    bit          sink_hold   = 1'b0;
    int unsigned sink_gap    = 0;

    priority_schedule_times #(
        .MAX_PROCS(JOB_SLOTS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // job_id[7:0], burst[23:8], prio[31:24]
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // out_id, completion, wait_time, totals, pad
        .o_m_tuser  (o_m_tuser),   // dropped
        .o_m_tlast  (o_m_tlast)
    );

    always #2 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d beats outstanding",
                     cycle_count, sched_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // mostly short pauses, now and then a long one
    function automatic int unsigned pick_pause();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    // stable priority order, running sums, one beat per stored job
    function automatic void predict_schedule(t_job job, logic last);
        t_job            order[$];
        t_sched_beat     beat;
        int              pos;
        longint unsigned clock_now;
        longint unsigned wait_sum;
        longint unsigned turn_sum;
        longint unsigned waited;
        if (pending_jobs.size() < JOB_SLOTS)
            pending_jobs.insert(pending_jobs.size(), job);
        else
            pending_dropped = 1'b1;
        if (!last)
            return;
        // a job lands behind every job of equal or lower priority value
        foreach (pending_jobs[i]) begin
            pos = order.size();
            while (pos > 0 && order[pos-1].prio > pending_jobs[i].prio)
                pos--;
            order.insert(pos, pending_jobs[i]);
        end
        clock_now = 0;
        wait_sum  = 0;
        turn_sum  = 0;
        foreach (order[i]) begin
            clock_now += order[i].burst;
            waited     = clock_now - order[i].burst;
            wait_sum  += waited;
            turn_sum  += clock_now;
            beat.data.pad            = '0;
            beat.data.out_id         = order[i].id;
            beat.data.completion     = clock_now[TIME_W-1:0];
            beat.data.wait_time      = waited[TIME_W-1:0];
            beat.data.tot_wait       = wait_sum[TOT_W-1:0];
            beat.data.tot_turnaround = turn_sum[TOT_W-1:0];
            beat.dropped             = pending_dropped;
            beat.last                = (i == order.size() - 1);
            sched_q.insert(sched_q.size(), beat);
        end
        if (pending_dropped)
            dropped_sets++;
        sets_sent++;
        pending_jobs.delete();
        pending_dropped = 1'b0;
    endfunction

    // every accepted job beat goes to the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            predict_schedule(t_job'(i_s_tdata), i_s_tlast);
    end

    function automatic void note_mismatch(string why, t_sched_beat want, t_sched_data got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch (%s) at cycle %0d", why, cycle_count);
            $display("  expected id=%0d cmpl=%0d wait=%0d twait=%0d tturn=%0d drop=%0b last=%0b",
                     want.data.out_id, want.data.completion, want.data.wait_time,
                     want.data.tot_wait, want.data.tot_turnaround, want.dropped, want.last);
            $display("  actual   id=%0d cmpl=%0d wait=%0d twait=%0d tturn=%0d drop=%0b last=%0b",
                     got.out_id, got.completion, got.wait_time, got.tot_wait,
                     got.tot_turnaround, o_m_tuser, o_m_tlast);
            if (got.pad !== '0)
                $display("  pad bits not zero: %b", got.pad);
        end
    endfunction

    // result beat check against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_sched_beat want;
        t_sched_data got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_sched_data'(o_m_tdata);
            beats_checked++;
            if (sched_q.size() == 0) begin
                want = '{data: '0, dropped: 1'b0, last: 1'b0};
                note_mismatch("no result expected", want, got);
            end else begin
                want = sched_q.pop_front();
                if (got.out_id !== want.data.out_id
                        || got.completion !== want.data.completion
                        || got.wait_time !== want.data.wait_time
                        || got.tot_wait !== want.data.tot_wait
                        || got.tot_turnaround !== want.data.tot_turnaround
                        || got.pad !== want.data.pad
                        || o_m_tuser !== want.dropped
                        || o_m_tlast !== want.last)
                    note_mismatch("field differs", want, got);
            end
        end
    end

    // sink: random stalls, or held off entirely on request
    always @(posedge i_clk) begin
        if (sink_hold) begin
            i_m_tready <= 1'b0;
        end else if (sink_gap != 0) begin
            i_m_tready <= 1'b0;
            sink_gap   <= sink_gap - 1;
        end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            i_m_tready <= 1'b0;
            sink_gap   <= pick_pause();
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic hold_sink(input int unsigned cycles);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        sink_hold <= 1'b0;
    endtask

    // one job beat, returns at the edge that accepts it
    task automatic send_job(input t_job job, input logic last);
        int unsigned gap;
        gap = 0;
        if (src_gaps && $urandom_range(0, 2) != 0)
            gap = pick_pause() + 1;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= job;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        jobs_sent++;
    endtask

    task automatic send_set(input t_job jobs[$]);
        foreach (jobs[i])
            send_job(jobs[i], i == jobs.size() - 1);
    endtask

    // source idles until the whole schedule has come back
    task automatic wait_for_schedule();
        i_s_tvalid <= 1'b0;
        // wait for a clock edge so the closing beat has reached the predictor
        @(posedge i_clk);
        while (sched_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_job make_job(logic [ID_W-1:0] id, logic [BURST_W-1:0] burst,
                                      logic [PRIO_W-1:0] prio);
        t_job job;
        job.id    = id;
        job.burst = burst;
        job.prio  = prio;
        return job;
    endfunction

    function automatic t_job rand_job(bit tie_heavy);
        t_job job;
        job.id = ID_W'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0:       job.burst = '0;
            1:       job.burst = '1;
            default: job.burst = BURST_W'($urandom_range(0, 65535));
        endcase
        if (tie_heavy)
            job.prio = PRIO_W'($urandom_range(0, 3));
        else if ($urandom_range(0, 7) == 0)
            job.prio = $urandom_range(0, 1) ? '1 : '0;
        else
            job.prio = PRIO_W'($urandom_range(0, 255));
        return job;
    endfunction

    // sets of a single job at both ends of every field
    task automatic test_single_job_sets();
        t_job jobs[$];
        src_gaps     = 1'b0;
        sink_stalls <= 1'b0;
        jobs = '{make_job(8'h00, 16'h0000, 8'h00)};
        send_set(jobs);
        jobs = '{make_job(8'hFF, 16'hFFFF, 8'hFF)};
        send_set(jobs);
        wait_for_schedule();
    endtask

    // mixed priorities, repeated values must keep arrival order
    task automatic test_service_order();
        t_job jobs[$];
        jobs = '{make_job(8'd1, 16'd5,    8'd255), make_job(8'd2, 16'd3,    8'd0),
                 make_job(8'd3, 16'd9,    8'd7),   make_job(8'd4, 16'd1,    8'd7),
                 make_job(8'd5, 16'd0,    8'd0),   make_job(8'd6, 16'd1000, 8'd128),
                 make_job(8'd7, 16'd2,    8'd7),   make_job(8'd8, 16'd4,    8'd255)};
        send_set(jobs);
        jobs = '{make_job(8'hAA, 16'h5555, 8'h55), make_job(8'h55, 16'hAAAA, 8'h55),
                 make_job(8'h0F, 16'h00FF, 8'h55)};
        send_set(jobs);
        wait_for_schedule();
    endtask

    // full chain of longest bursts, then jobs past capacity incl. the closing one
    task automatic test_capacity_overflow();
        t_job jobs[$];
        src_gaps     = 1'b1;
        sink_stalls <= 1'b1;
        for (int i = 0; i < JOB_SLOTS + 2; i++)
            jobs.insert(jobs.size(),
                        make_job(i[ID_W-1:0], 16'hFFFF, PRIO_W'($urandom_range(0, 255))));
        send_set(jobs);
        // the following set must come back without the dropped flag
        jobs = '{make_job(8'd200, 16'd10, 8'd1), make_job(8'd201, 16'd20, 8'd0)};
        send_set(jobs);
        wait_for_schedule();
    endtask

    // sink held off while the source keeps offering back-to-back jobs
    task automatic test_backpressure();
        t_job jobs[$];
        src_gaps     = 1'b0;
        sink_stalls <= 1'b0;
        fork
            hold_sink(150);
        join_none
        for (int i = 0; i < 20; i++)
            jobs.insert(jobs.size(), rand_job(i[0]));
        send_set(jobs);
        jobs.delete();
        for (int i = 0; i < 12; i++)
            jobs.insert(jobs.size(), rand_job(1'b0));
        send_set(jobs);
        wait_for_schedule();
    endtask

    // random sets, mostly short, some full and some overflowing
    task automatic test_random_sets();
        t_job        jobs[$];
        int unsigned set_len;
        int unsigned start_jobs;
        bit          tie_heavy;
        start_jobs = jobs_sent;
        while (jobs_sent - start_jobs < RANDOM_JOBS) begin
            src_gaps     = ($urandom_range(0, 3) != 0);
            sink_stalls <= ($urandom_range(0, 3) != 0);
            tie_heavy    = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0:       set_len = $urandom_range(JOB_SLOTS, JOB_SLOTS + 4);
                1, 2:    set_len = $urandom_range(9, JOB_SLOTS - 1);
                default: set_len = $urandom_range(1, 8);
            endcase
            jobs.delete();
            repeat (set_len) jobs.insert(jobs.size(), rand_job(tie_heavy));
            send_set(jobs);
            if ($urandom_range(0, 3) == 0)
                wait_for_schedule();
        end
        wait_for_schedule();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        i_m_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_job_sets();
        test_service_order();
        test_capacity_overflow();
        test_backpressure();
        test_random_sets();

        wait_for_schedule();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d jobs in %0d sets scheduled, %0d with overflow, %0d result beats checked",
                 jobs_sent, sets_sent, dropped_sets, beats_checked);
        $display("%0d mismatches, %0d results never delivered", mismatch_count, sched_q.size());
        if (mismatch_count == 0 && sched_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
